FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset.
`define SFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/sfc_pkg.sv
`default_nettype none
package sfc_pkg;

    localparam int unsigned StoreBytes   = 18;
    localparam int unsigned ValueCount   = 9;
    localparam int unsigned QueueDepthDef = 2;
    localparam int unsigned CfgIdxW      = 2;

    localparam logic [7:0] SyncByteRst   = 8'hAA;
    localparam logic [7:0] RecordTypeRst = 8'h02;

    localparam logic [CfgIdxW-1:0] CfgSyncByte   = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgRecordType = 2'd1;

    typedef enum logic [1:0] {
        ST_RECORD  = 2'd0,
        ST_BAD_SUM = 2'd1,
        ST_OTHER   = 2'd2,
        ST_SHORT   = 2'd3
    } t_status;

    typedef struct packed {
        t_status                         status;
        logic [7:0]                      ftype;
        logic [StoreBytes-1:0][7:0]      vbytes;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

FILE: src/sfc_front.sv
`default_nettype none
module sfc_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire logic [7:0]     i_rx_byte,
    input  wire logic [7:0]     i_sync_byte,
    input  wire logic [7:0]     i_record_type,
    input  sfc_pkg::t_q_stat    i_q_stat,
    output logic                o_push,
    output sfc_pkg::t_entry     o_entry
);
    import sfc_pkg::*;

    typedef enum logic [5:0] {
        PH_SYNC1   = 6'b000001,
        PH_SYNC2   = 6'b000010,
        PH_TYPE    = 6'b000100,
        PH_LEN     = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_CHECK   = 6'b100000
    } t_phase;

    t_phase r_phase, n_phase;
    logic [7:0] r_type, n_type;
    logic [7:0] r_len, n_len;
    logic [7:0] r_seen, n_seen;
    logic [7:0] r_sum, n_sum;
    logic [StoreBytes-1:0][7:0] r_vbytes;

    logic       accept;
    logic [7:0] seen_inc;
    logic [7:0] expect_sum;
    t_status    status;

    assign o_in_stall = i_q_stat.full;
    assign accept     = i_in_valid && !i_q_stat.full;
    assign seen_inc   = r_seen + 8'd1;
    assign expect_sum = r_sum + i_sync_byte + i_sync_byte;

    always_comb begin
        if (i_rx_byte != expect_sum) begin
            status = ST_BAD_SUM;
        end else if (r_type != i_record_type) begin
            status = ST_OTHER;
        end else if (r_len < 8'(StoreBytes)) begin
            status = ST_SHORT;
        end else begin
            status = ST_RECORD;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_type  = r_type;
        n_len   = r_len;
        n_seen  = r_seen;
        n_sum   = r_sum;
        o_push  = 1'b0;
        if (accept) begin
            case (r_phase)
                PH_SYNC1: begin
                    if (i_rx_byte == i_sync_byte) begin
                        n_phase = PH_SYNC2;
                    end
                end
                PH_SYNC2: begin
                    n_phase = (i_rx_byte == i_sync_byte) ? PH_TYPE : PH_SYNC1;
                end
                PH_TYPE: begin
                    n_type  = i_rx_byte;
                    n_sum   = i_rx_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len   = i_rx_byte;
                    n_sum   = r_sum + i_rx_byte;
                    n_seen  = 8'd0;
                    n_phase = (i_rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    n_sum  = r_sum + i_rx_byte;
                    n_seen = seen_inc;
                    if (seen_inc >= r_len) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    o_push  = 1'b1;
                    n_phase = PH_SYNC1;
                end
                default: begin
                    n_phase = PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_type  <= 8'd0;
            r_len   <= 8'd0;
            r_seen  <= 8'd0;
            r_sum   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (r_phase == PH_PAYLOAD) && (r_seen < 8'(StoreBytes))) begin
            r_vbytes[r_seen[4:0]] <= i_rx_byte;
        end
    end

    assign o_entry.status = status;
    assign o_entry.ftype  = r_type;
    assign o_entry.vbytes = r_vbytes;

endmodule
`default_nettype wire

FILE: src/sfc_queue.sv
`default_nettype none
module sfc_queue #(
    parameter int unsigned Depth = sfc_pkg::QueueDepthDef
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  sfc_pkg::t_entry     i_entry,
    input  wire logic           i_pop,
    output sfc_pkg::t_entry     o_entry,
    output sfc_pkg::t_q_stat    o_stat
);
    import sfc_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    t_entry r_mem [Depth];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic do_push, do_pop;

    assign o_stat.full  = (r_cnt == CntW'(Depth));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + PtrW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CntW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

FILE: src/sfc_back.sv
`default_nettype none
module sfc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  sfc_pkg::t_entry     i_entry,
    input  sfc_pkg::t_q_stat    i_q_stat,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic [1:0]          o_status,
    output logic [7:0]          o_ftype,
    output logic [sfc_pkg::ValueCount-1:0][15:0] o_values
);
    import sfc_pkg::*;

    logic                       r_valid;
    logic [1:0]                 r_status;
    logic [7:0]                 r_ftype;
    logic [ValueCount-1:0][15:0] r_values, n_values;

    assign o_pop = !i_q_stat.empty && (!r_valid || !i_out_stall);

    always_comb begin
        for (int k = 0; k < ValueCount; k++) begin
            if (i_entry.status == ST_RECORD) begin
                n_values[k] = {i_entry.vbytes[2*k], i_entry.vbytes[2*k+1]};
            end else begin
                n_values[k] = 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= i_entry.status;
            r_ftype  <= i_entry.ftype;
            r_values <= n_values;
        end
    end

    assign o_out_valid = r_valid;
    assign o_status    = r_status;
    assign o_ftype     = r_ftype;
    assign o_values    = r_values;

endmodule
`default_nettype wire

FILE: src/sync_frame_checksum_imu_parser.sv
// Channel  | Direction | Handshake               | Payload
// -------- | --------- | ----------------------- | ------------------------------------
// in       | input     | i_in_valid / o_in_stall | i_rx_byte
// out      | output    | o_out_valid / i_out_stall | o_frame_status, o_frame_type, values
// cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One byte request is taken per cycle unless stalled; the parser state updates in the cycle
// it is taken. A result is queued on its checksum byte, then moved into the output register.
// The input stalls only while the result queue between parser and output register is full.
// Reset is synchronous and active low; it returns the parser to the sync hunt and empties the
// queue and output register. Configuration writes are always ready.
`default_nettype none
module sync_frame_checksum_imu_parser #(
    parameter int unsigned QueueDepth = sfc_pkg::QueueDepthDef
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [7:0]                  i_rx_byte,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [1:0]                       o_frame_status,
    output logic [7:0]                       o_frame_type,
    output logic signed [15:0]               o_accel_x,
    output logic signed [15:0]               o_accel_y,
    output logic signed [15:0]               o_accel_z,
    output logic signed [15:0]               o_gyro_x,
    output logic signed [15:0]               o_gyro_y,
    output logic signed [15:0]               o_gyro_z,
    output logic signed [15:0]               o_mag_x,
    output logic signed [15:0]               o_mag_y,
    output logic signed [15:0]               o_mag_z,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [sfc_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [7:0]                  i_cfg_data
);
    import sfc_pkg::*;

    logic [7:0] r_sync_byte;
    logic [7:0] r_record_type;

    t_entry  front_entry;
    t_entry  queue_entry;
    t_q_stat q_stat;
    logic    push;
    logic    pop;
    logic [ValueCount-1:0][15:0] values;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte   <= SyncByteRst;
            r_record_type <= RecordTypeRst;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgSyncByte:   r_sync_byte   <= i_cfg_data;
                CfgRecordType: r_record_type <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sfc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_rx_byte     (i_rx_byte),
        .i_sync_byte   (r_sync_byte),
        .i_record_type (r_record_type),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_entry       (front_entry)
    );

    sfc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_entry (queue_entry),
        .o_stat  (q_stat)
    );

    sfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (queue_entry),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_frame_status),
        .o_ftype     (o_frame_type),
        .o_values    (values)
    );

    assign o_accel_x = signed'(values[0]);
    assign o_accel_y = signed'(values[1]);
    assign o_accel_z = signed'(values[2]);
    assign o_gyro_x  = signed'(values[3]);
    assign o_gyro_y  = signed'(values[4]);
    assign o_gyro_z  = signed'(values[5]);
    assign o_mag_x   = signed'(values[6]);
    assign o_mag_y   = signed'(values[7]);
    assign o_mag_z   = signed'(values[8]);

endmodule
`default_nettype wire

FILE: src/sfc_checker.sv
`default_nettype none
`include "assert_macros.svh"
module sfc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic [1:0]         o_frame_status,
    input wire logic [7:0]         o_frame_type,
    input wire logic signed [15:0] o_accel_x,
    input wire logic signed [15:0] o_accel_y,
    input wire logic signed [15:0] o_accel_z,
    input wire logic signed [15:0] o_gyro_x,
    input wire logic signed [15:0] o_gyro_y,
    input wire logic signed [15:0] o_gyro_z,
    input wire logic signed [15:0] o_mag_x,
    input wire logic signed [15:0] o_mag_y,
    input wire logic signed [15:0] o_mag_z,
    input wire logic               o_cfg_ready
);
    import sfc_pkg::*;

    `SFC_ASSERT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frame_status) && $stable(o_frame_type) && $stable(o_accel_x), "stalled result changed")
    `SFC_ASSERT(a_zero, i_clk, i_rst_n, o_out_valid && (o_frame_status != ST_RECORD) |-> (o_accel_x == 16'sd0) && (o_accel_y == 16'sd0) && (o_accel_z == 16'sd0) && (o_gyro_x == 16'sd0) && (o_gyro_y == 16'sd0) && (o_gyro_z == 16'sd0) && (o_mag_x == 16'sd0) && (o_mag_y == 16'sd0) && (o_mag_z == 16'sd0), "values not zero on a non-record status")
    `SFC_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `SFC_ASSERT(a_cfg, i_clk, i_rst_n, o_cfg_ready, "configuration port not ready")

endmodule

bind sync_frame_checksum_imu_parser sfc_checker u_sfc_checker (.*);
`default_nettype wire

FILE: tb/sv/imu_frame_checker.sv
`timescale 1ns / 100ps
module imu_frame_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_stall,
    input  wire logic [7:0]                  i_rx_byte,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_stall,
    input  wire logic [1:0]                  i_frame_status,
    input  wire logic [7:0]                  i_frame_type,
    input  wire logic signed [15:0]          i_accel_x,
    input  wire logic signed [15:0]          i_accel_y,
    input  wire logic signed [15:0]          i_accel_z,
    input  wire logic signed [15:0]          i_gyro_x,
    input  wire logic signed [15:0]          i_gyro_y,
    input  wire logic signed [15:0]          i_gyro_z,
    input  wire logic signed [15:0]          i_mag_x,
    input  wire logic signed [15:0]          i_mag_y,
    input  wire logic signed [15:0]          i_mag_z,
    input  wire logic                        i_cfg_valid,
    input  wire logic                        i_cfg_ready,
    input  wire logic [sfc_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [7:0]                  i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_records,
    output int                               o_bad_sums,
    output int                               o_other_types,
    output int                               o_short_frames
);
    import sfc_pkg::*;

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        TAKE_TYPE,
        TAKE_LENGTH,
        TAKE_PAYLOAD,
        TAKE_CHECK
    } parse_phase_e;

    typedef struct packed {
        t_status                     status;
        logic [7:0]                  ftype;
        logic [ValueCount-1:0][15:0] values;
    } frame_result_t;

    frame_result_t pending_frames[$];
    parse_phase_e  phase;
    logic [7:0]    sync_byte;
    logic [7:0]    record_type;
    logic [7:0]    held_type;
    logic [7:0]    held_length;
    logic [7:0]    bytes_seen;
    logic [7:0]    running_sum;
    logic [7:0]    value_bytes [StoreBytes];
    string         value_names [ValueCount] = '{"accel_x", "accel_y", "accel_z",
                                                "gyro_x", "gyro_y", "gyro_z",
                                                "mag_x", "mag_y", "mag_z"};

    task automatic parse_rx_byte(input logic [7:0] b);
        frame_result_t r;
        logic [7:0]    want_sum;
        int            k;
        case (phase)
            HUNT_FIRST: begin
                if (b == sync_byte) phase = HUNT_SECOND;
            end
            HUNT_SECOND: begin
                phase = (b == sync_byte) ? TAKE_TYPE : HUNT_FIRST;
            end
            TAKE_TYPE: begin
                held_type   = b;
                running_sum = b;
                phase       = TAKE_LENGTH;
            end
            TAKE_LENGTH: begin
                held_length = b;
                running_sum = running_sum + b;
                bytes_seen  = 8'd0;
                phase       = (b == 8'd0) ? TAKE_CHECK : TAKE_PAYLOAD;
            end
            TAKE_PAYLOAD: begin
                if (bytes_seen < StoreBytes) value_bytes[bytes_seen[4:0]] = b;
                running_sum = running_sum + b;
                bytes_seen  = bytes_seen + 8'd1;
                if (bytes_seen >= held_length) phase = TAKE_CHECK;
            end
            TAKE_CHECK: begin
                want_sum = running_sum + sync_byte + sync_byte;
                if (b != want_sum) begin
                    r.status = ST_BAD_SUM;
                end else if (held_type != record_type) begin
                    r.status = ST_OTHER;
                end else if (held_length < StoreBytes) begin
                    r.status = ST_SHORT;
                end else begin
                    r.status = ST_RECORD;
                end
                r.ftype = held_type;
                for (k = 0; k < ValueCount; k++) begin
                    r.values[k] = (r.status == ST_RECORD) ?
                                  {value_bytes[2*k], value_bytes[2*k+1]} : 16'h0000;
                end
                pending_frames.push_back(r);
                phase = HUNT_FIRST;
            end
            default: begin
                phase = HUNT_FIRST;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        frame_result_t               want;
        logic [ValueCount-1:0][15:0] got;
        int                          k;
        if (!i_rst_n) begin
            pending_frames.delete();
            phase       = HUNT_FIRST;
            sync_byte   = SyncByteRst;
            record_type = RecordTypeRst;
            held_type   = 8'd0;
            held_length = 8'd0;
            bytes_seen  = 8'd0;
            running_sum = 8'd0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_frames.size() == 0) begin
                    $error("result with no frame pending: status %0d, type %0d",
                           i_frame_status, i_frame_type);
                    o_fail_count++;
                end else begin
                    want = pending_frames.pop_front();
                    got  = {i_mag_z, i_mag_y, i_mag_x, i_gyro_z, i_gyro_y, i_gyro_x,
                            i_accel_z, i_accel_y, i_accel_x};
                    if (i_frame_status !== want.status) begin
                        $error("frame_status: expected %0d, got %0d", want.status,
                               i_frame_status);
                        o_fail_count++;
                    end
                    if (i_frame_type !== want.ftype) begin
                        $error("frame_type: expected %0d, got %0d", want.ftype, i_frame_type);
                        o_fail_count++;
                    end
                    for (k = 0; k < ValueCount; k++) begin
                        if (got[k] !== want.values[k]) begin
                            $error("%s: expected %0d, got %0d", value_names[k],
                                   $signed(want.values[k]), $signed(got[k]));
                            o_fail_count++;
                        end
                    end
                    case (want.status)
                        ST_RECORD:  o_records++;
                        ST_BAD_SUM: o_bad_sums++;
                        ST_OTHER:   o_other_types++;
                        default:    o_short_frames++;
                    endcase
                end
            end
            if (i_in_valid && !i_in_stall) parse_rx_byte(i_rx_byte);
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CfgSyncByte) begin
                    sync_byte = i_cfg_data;
                end else if (i_cfg_index == CfgRecordType) begin
                    record_type = i_cfg_data;
                end
            end
        end
        o_pending = pending_frames.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
module testbench;
    import sfc_pkg::*;

    localparam int CycleLimit    = 400000;
    localparam int BytesPerPhase = 70;
    localparam int IdlePercent   = 38;

    localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_EXTREMES} payload_fill_e;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic [7:0]         rx_byte   = 8'd0;
    logic               out_stall = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = CfgSyncByte;
    logic [7:0]         cfg_data  = 8'd0;
    logic               in_stall;
    logic               out_valid;
    logic               cfg_ready;
    logic [1:0]         frame_status;
    logic [7:0]         frame_type;
    logic signed [15:0] accel_x, accel_y, accel_z;
    logic signed [15:0] gyro_x, gyro_y, gyro_z;
    logic signed [15:0] mag_x, mag_y, mag_z;

    int   fail_count;
    int   pending_count;
    int   records;
    int   bad_sums;
    int   other_types;
    int   short_frames;
    int   cycles       = 0;
    int   bytes_sent   = 0;
    int   framed_bytes = 0;
    logic calm         = 1'b0;
    logic [7:0] sync_now  = SyncByteRst;
    logic [7:0] rtype_now = RecordTypeRst;

    sync_frame_checksum_imu_parser i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_frame_status (frame_status),
        .o_frame_type   (frame_type),
        .o_accel_x      (accel_x),
        .o_accel_y      (accel_y),
        .o_accel_z      (accel_z),
        .o_gyro_x       (gyro_x),
        .o_gyro_y       (gyro_y),
        .o_gyro_z       (gyro_z),
        .o_mag_x        (mag_x),
        .o_mag_y        (mag_y),
        .o_mag_z        (mag_z),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    imu_frame_checker u_frame_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_rx_byte      (rx_byte),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_frame_status (frame_status),
        .i_frame_type   (frame_type),
        .i_accel_x      (accel_x),
        .i_accel_y      (accel_y),
        .i_accel_z      (accel_z),
        .i_gyro_x       (gyro_x),
        .i_gyro_y       (gyro_y),
        .i_gyro_z       (gyro_z),
        .i_mag_x        (mag_x),
        .i_mag_y        (mag_y),
        .i_mag_z        (mag_z),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count),
        .o_records      (records),
        .o_bad_sums     (bad_sums),
        .o_other_types  (other_types),
        .o_short_frames (short_frames)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < IdlePercent);
    end

    // Entered and left at a falling edge; the request is held until it is taken.
    task automatic send_byte(input logic [7:0] b);
        while (!calm && ($urandom_range(99) < IdlePercent)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [7:0] len,
                              input payload_fill_e fill, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        int         k;
        sum = ftype + len + sync_now + sync_now;
        send_byte(sync_now);
        send_byte(sync_now);
        send_byte(ftype);
        send_byte(len);
        for (k = 0; k < len; k++) begin
            case (fill)
                FILL_ZERO:     b = 8'h00;
                FILL_ONES:     b = 8'hFF;
                FILL_EXTREMES: b = (k % 4 == 0) ? 8'h80 : (k % 4 == 1) ? 8'h00 :
                                   (k % 4 == 2) ? 8'h7F : 8'hFF;
                default:       b = 8'($urandom_range(255));
            endcase
            sum = sum + b;
            send_byte(b);
        end
        if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
        send_byte(sum);
        framed_bytes += len + 5;
    endtask

    // Mostly whole random frames, plus noise, broken headers and truncated payloads.
    task automatic send_random_traffic();
        int         pick;
        int         cut;
        logic [7:0] len;
        pick = $urandom_range(99);
        if (pick < 50) begin
            len = ($urandom_range(39) == 0) ? 8'($urandom_range(25, 255)) :
                                              8'($urandom_range(18, 24));
            send_frame(rtype_now, len, FILL_RANDOM, 1'b0);
        end else if (pick < 60) begin
            send_frame(rtype_now, 8'($urandom_range(17)), FILL_RANDOM, 1'b0);
        end else if (pick < 70) begin
            send_frame($urandom_range(1) ? rtype_now : 8'($urandom_range(255)),
                       8'($urandom_range(24)), FILL_RANDOM, 1'b1);
        end else if (pick < 80) begin
            send_frame(8'($urandom_range(255)), 8'($urandom_range(24)), FILL_RANDOM, 1'b0);
        end else if (pick < 90) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
        end else if (pick < 95) begin
            send_byte(sync_now);
            send_byte(sync_now ^ 8'($urandom_range(1, 255)));
            framed_bytes += 2;
        end else begin
            len = 8'($urandom_range(1, 24));
            cut = $urandom_range(len - 1);
            send_byte(sync_now);
            send_byte(sync_now);
            send_byte(rtype_now);
            send_byte(len);
            repeat (cut) send_byte(8'($urandom_range(255)));
            framed_bytes += 4 + cut;
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [7:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CfgSyncByte) begin
            sync_now = d;
        end else if (idx == CfgRecordType) begin
            rtype_now = d;
        end
        @(negedge clk);
    endtask

    task automatic run_phase();
        int stop;
        stop = framed_bytes + BytesPerPhase;
        while (framed_bytes < stop) begin
            send_random_traffic();
        end
    endtask

    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_frame(rtype_now, 8'd18, FILL_ZERO, 1'b0);
        send_frame(rtype_now, 8'd18, FILL_ONES, 1'b0);
        send_frame(rtype_now, 8'd18, FILL_EXTREMES, 1'b0);
        send_byte(sync_now);
        send_byte(~sync_now);
        send_frame(rtype_now, 8'd19, FILL_RANDOM, 1'b0);
        send_frame(rtype_now, 8'd18, FILL_RANDOM, 1'b1);
        send_frame(~rtype_now, 8'd18, FILL_RANDOM, 1'b0);
        send_frame(rtype_now, 8'd17, FILL_RANDOM, 1'b0);
        send_frame(rtype_now, 8'd0, FILL_RANDOM, 1'b0);
        // A bad sum outranks a wrong type, which outranks a short payload.
        send_frame(~rtype_now, 8'd3, FILL_RANDOM, 1'b1);
        send_frame(~rtype_now, 8'd3, FILL_RANDOM, 1'b0);
        send_frame(rtype_now, 8'd255, FILL_RANDOM, 1'b0);
        run_phase();

        settle();
        write_register(CfgSyncByte, 8'h00);
        write_register(CfgRecordType, 8'h00);
        write_register(CfgSpareLo, 8'($urandom_range(255)));
        run_phase();

        settle();
        write_register(CfgSyncByte, 8'hFF);
        write_register(CfgRecordType, 8'hFF);
        write_register(CfgSpareHi, 8'($urandom_range(255)));
        calm <= 1'b1;
        run_phase();
        calm <= 1'b0;

        settle();
        write_register(CfgSyncByte, 8'($urandom_range(255)));
        write_register(CfgRecordType, 8'($urandom_range(255)));
        run_phase();

        settle();
        write_register(CfgSyncByte, SyncByteRst);
        write_register(CfgRecordType, RecordTypeRst);
        run_phase();

        settle();
        repeat (8) @(negedge clk);
        $display("Sent %0d bytes over five register settings; checked %0d frames:",
                 bytes_sent, records + bad_sums + other_types + short_frames);
        $display("%0d sensor records, %0d bad sums, %0d other types, %0d too short.",
                 records, bad_sums, other_types, short_frames);
        if (fail_count == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sync_frame_checksum_imu_parser.f
+incdir+src
src/sfc_pkg.sv
src/sfc_front.sv
src/sfc_queue.sv
src/sfc_back.sv
src/sync_frame_checksum_imu_parser.sv
src/sfc_checker.sv
tb/sv/imu_frame_checker.sv
tb/sv/testbench.sv
